/* hdl/pba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int PAGE_W            = 10;
  localparam int COUNT_W           = 11;
  localparam int PAGE_TOTAL_DEF    = 1024;
  localparam int MAP_WORD_BITS_DEF = 32;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [PAGE_W-1:0]  granted_page;
    logic [PAGE_W-1:0]  owner_tag;
    logic [COUNT_W-1:0] pages_in_use;
  } rsp_t;

endpackage

/* hdl/page_bitmap_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core
// First-fit page allocator over a one-bit-per-page map held in a RAM.
// ----------------------------------------------------------------------------
// allocate: the scan reads map words from word 0 up to the first one with a clear
//   bit (one RAM word read per cycle, up to 32 words), then gives the done beat
// free: one read, a write back if the page was taken, then the done beat
// busy clears in the cycle of the done beat; one command at a time
// reset: map clear pass over all PAGE_TOTAL/MAP_WORD_BITS map words (32) with busy high,
//   page 0 taken, count 1; results are a single-cycle beat, never stalled
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core #(
  parameter int PAGE_TOTAL    = pba_pkg::PAGE_TOTAL_DEF,
  parameter int MAP_WORD_BITS = pba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pba_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output pba_pkg::rsp_t result
);

  import pba_pkg::*;

  localparam int MapWords = (PAGE_TOTAL + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int PosW     = $clog2(MAP_WORD_BITS);
  localparam int SpanW    = $clog2(MapWords * MAP_WORD_BITS) + 1;
  localparam int FullW    = (SpanW > PAGE_W + 1) ? SpanW : PAGE_W + 1;
  localparam int LastWord = MapWords - 1;
  localparam int TailBits = PAGE_TOTAL - LastWord * MAP_WORD_BITS;
  localparam int DivShift = PAGE_W + PosW;
  localparam int DivMul   = (1 << DivShift) / MAP_WORD_BITS + 1;
  localparam int ProdW    = 2 * PAGE_W + 1;
  localparam int QuotW    = ProdW - DivShift;
  localparam logic [MAP_WORD_BITS-1:0] TailFill = {MAP_WORD_BITS{1'b1}} << TailBits;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FREE  = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [AddrW-1:0]    word_idx;
  logic [PAGE_W-1:0]   req_idx;
  logic                req_ok;
  logic [COUNT_W-1:0]  count;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic [AddrW-1:0]    ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;

  logic [ProdW-1:0]    div_prod;
  logic [QuotW-1:0]    div_q;
  logic                in_range;
  logic [AddrW-1:0]    free_word;
  logic [PosW-1:0]     free_pos;
  logic                free_taken;
  logic [MAP_WORD_BITS-1:0] free_mask;

  logic [MAP_WORD_BITS-1:0] scan_word;
  logic                last_word;
  logic                found;
  logic [PosW-1:0]     found_pos;
  logic [MAP_WORD_BITS-1:0] found_mask;
  logic [FullW-1:0]    alloc_page;

  logic                accept;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign last_word = (word_idx == AddrW'(LastWord));

  // word of a page index by reciprocal multiply, exact for all 10-bit indexes
  assign div_prod  = ProdW'(request.page_index) * ProdW'(DivMul);
  assign div_q     = div_prod[ProdW-1:DivShift];
  assign in_range  = (FullW'(request.page_index) < FullW'(PAGE_TOTAL));
  assign free_word = in_range ? AddrW'(div_q) : '0;

  assign free_pos   = PosW'(FullW'(req_idx) - FullW'(word_idx) * FullW'(MAP_WORD_BITS));
  assign free_mask  = MAP_WORD_BITS'(1) << free_pos;
  assign free_taken = |(ram_rdata & free_mask);

  assign scan_word  = ram_rdata | (last_word ? TailFill : '0);
  assign alloc_page = FullW'(word_idx) * FullW'(MAP_WORD_BITS) + FullW'(found_pos);

  pba_find #(
    .WIDTH (MAP_WORD_BITS)
  ) u_find (
    .word   (scan_word),
    .found  (found),
    .pos    (found_pos),
    .onehot (found_mask)
  );

  pba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MapWords)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = word_idx;
    ram_wdata  = ram_rdata;
    ram_raddr  = word_idx;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (word_idx == '0) ? MAP_WORD_BITS'(1) : '0;
        if (last_word) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (request.cmd == CMD_ALLOC) begin
            ram_raddr  = '0;
            state_next = S_SCAN;
          end else begin
            ram_raddr  = free_word;
            state_next = S_FREE;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = word_idx + AddrW'(1);
        if (found) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata | found_mask;
          state_next = S_IDLE;
        end else if (last_word) begin
          state_next = S_IDLE;
        end
      end
      S_FREE: begin
        if (req_ok && free_taken) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~free_mask;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      word_idx <= '0;
      count    <= COUNT_W'(1);
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          word_idx <= word_idx + AddrW'(1);
        end
        S_IDLE: begin
          word_idx <= ram_raddr;
          if (accept) begin
            req_idx <= request.page_index;
            req_ok  <= in_range;
          end
        end
        S_SCAN: begin
          word_idx <= ram_raddr;
          if (found) begin
            done   <= 1'b1;
            count  <= count + COUNT_W'(1);
            result <= '{status: ST_OK, granted_page: PAGE_W'(alloc_page),
                        owner_tag: PAGE_W'(count),
                        pages_in_use: count + COUNT_W'(1)};
          end else if (last_word) begin
            done   <= 1'b1;
            result <= '{status: ST_FULL, granted_page: '0, owner_tag: '0,
                        pages_in_use: count};
          end
        end
        S_FREE: begin
          done <= 1'b1;
          if (req_ok && free_taken) begin
            count  <= count - COUNT_W'(1);
            result <= '{status: ST_OK, granted_page: req_idx, owner_tag: '0,
                        pages_in_use: count - COUNT_W'(1)};
          end else begin
            result <= '{status: ST_BAD, granted_page: '0, owner_tag: '0,
                        pages_in_use: count};
          end
        end
        default: begin
          word_idx <= '0;
        end
      endcase
    end
  end

  // a result beat always closes a command that held busy
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result beat without a command in flight");

  // an accepted command keeps the block busy in the following cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> busy && !done)
    else $error("accepted command did not occupy the block");

  // the page count can never exceed the map size
  assert property (@(posedge clk) disable iff (rst) int'(count) <= PAGE_TOTAL)
    else $error("page count above map size");

endmodule

/* hdl/pba_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pba_find.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_find
// Lowest clear bit search over one map word: one-hot mask and bit position.
// ----------------------------------------------------------------------------
module pba_find #(
  parameter int WIDTH = 32,
  localparam int PW   = $clog2(WIDTH)
) (
  input  logic [WIDTH-1:0] word,
  output logic             found,
  output logic [PW-1:0]    pos,
  output logic [WIDTH-1:0] onehot
);

  logic [WIDTH-1:0] zeros;

  assign zeros  = ~word;
  assign onehot = zeros & (~zeros + WIDTH'(1));
  assign found  = |zeros;

  // encode the one-hot mask, each position bit is an independent or
  always_comb begin
    pos = '0;
    for (int b = 0; b < PW; b++) begin
      for (int j = 0; j < WIDTH; j++) begin
        if (((j >> b) & 1) == 1) begin
          pos[b] = pos[b] | onehot[j];
        end
      end
    end
  end

endmodule
